// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FFWB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that implies a consequence in the same cycle.
`define FFWB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies a consequence in the following cycle.
`define FFWB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ffwb_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame window buffer package
// Sizes, command codes and the structures passed between the block's modules.
// ----------------------------------------------------------------------------
package ffwb_pkg;

    // Store geometry. FRAMES is a power of two, so the frame index wraps by
    // dropping the carry.
    localparam int FRAMES     = 32;
    localparam int COEFS      = 16;
    localparam int DEPTH      = FRAMES * COEFS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int PTR_W      = $clog2(FRAMES);

    // Field widths of the request and result.
    localparam int CMD_W      = 2;
    localparam int COEF_IDX_W = 4;
    localparam int OFS_W      = 5;
    localparam int VAL_W      = 8;
    localparam int SUM_W      = ((PTR_W > OFS_W) ? PTR_W : OFS_W) + 1;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_WRITE   = 2'd0;
    localparam cmd_t CMD_COMMIT  = 2'd1;
    localparam cmd_t CMD_READ    = 2'd2;
    localparam cmd_t CMD_CONSUME = 2'd3;

    typedef struct packed {
        cmd_t                   cmd;
        logic [COEF_IDX_W-1:0]  coef_index;
        logic [OFS_W-1:0]       frame_offset;
        logic [VAL_W-1:0]       coef_value;
    } req_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic rd_ok;
        logic ready_res;
        logic filled;
    } meta_t;

    typedef struct packed {
        logic [PTR_W-1:0] wp;
        logic [PTR_W-1:0] lch;
        logic             filled;
    } state_t;

endpackage

// ===== design/ffwb_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one buffer command and its operands.
// ----------------------------------------------------------------------------
interface ffwb_req_if;

    logic                                    valid;
    logic                                    ready;
    logic [ffwb_pkg::CMD_W-1:0]              cmd;
    logic [ffwb_pkg::COEF_IDX_W-1:0]         coef_index;
    logic [ffwb_pkg::OFS_W-1:0]              frame_offset;
    logic signed [ffwb_pkg::VAL_W-1:0]       coef_value;

    modport source (output valid, output cmd, output coef_index,
                    output frame_offset, output coef_value, input ready);
    modport sink   (input valid, input cmd, input coef_index,
                    input frame_offset, input coef_value, output ready);

endinterface

// ===== design/ffwb_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per accepted request.
// ----------------------------------------------------------------------------
interface ffwb_res_if;

    logic                              valid;
    logic                              ready;
    logic signed [ffwb_pkg::VAL_W-1:0] read_value;
    logic                              ready_res;
    logic                              filled;

    modport source (output valid, output read_value, output ready_res,
                    output filled, input ready);
    modport sink   (input valid, input read_value, input ready_res,
                    input filled, output ready);

endinterface

// ===== design/ffwb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address a cycle, used for a write, a read or both, with registered read data.
// ----------------------------------------------------------------------------
module ffwb_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffwb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window buffer control
// Holds the write pointer, consumed head and filled flag, and turns each
// accepted request into at most one store access and its result status.
// ----------------------------------------------------------------------------
module ffwb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ffwb_pkg::req_t    req_pl,
    output ffwb_pkg::mem_req_t mem_req,
    output ffwb_pkg::meta_t   meta,
    output ffwb_pkg::state_t  st
);

    import ffwb_pkg::*;

    state_t           st_reg;
    state_t           st_next;
    logic             coef_ok;
    logic [SUM_W-1:0] rd_sum;
    logic [PTR_W-1:0] rd_frame;
    logic [PTR_W-1:0] frame;
    logic [PTR_W-1:0] lch_plus1;

    assign coef_ok  = 32'(req_pl.coef_index) < COEFS;
    assign rd_sum   = SUM_W'(st_reg.wp) + SUM_W'(req_pl.frame_offset);
    assign rd_frame = rd_sum[PTR_W-1:0];

    always_comb
    begin
        st_next       = st_reg;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.wdata = req_pl.coef_value;
        meta.rd_ok    = 1'b0;
        frame         = st_reg.wp;

        if (accept)
        begin
            case (req_pl.cmd)
                CMD_WRITE:
                begin
                    mem_req.we = coef_ok;
                end
                CMD_COMMIT:
                begin
                    if (st_reg.wp == PTR_W'(FRAMES - 1))
                    begin
                        st_next.wp     = '0;
                        st_next.filled = 1'b1;
                    end
                    else
                    begin
                        st_next.wp = st_reg.wp + PTR_W'(1);
                    end
                end
                CMD_READ:
                begin
                    frame      = rd_frame;
                    mem_req.re = coef_ok;
                    meta.rd_ok = coef_ok;
                end
                CMD_CONSUME:
                begin
                    if (st_reg.wp == '0)
                    begin
                        st_next.lch = PTR_W'(FRAMES - 1);
                    end
                    else
                    begin
                        st_next.lch = st_reg.wp - PTR_W'(1);
                    end
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end

        mem_req.addr = ADDR_W'(frame) * ADDR_W'(COEFS) + ADDR_W'(req_pl.coef_index);

        // The window is ready once filled and the pointer differs from the
        // frame following the consumed head, judged on the updated state.
        lch_plus1      = (st_next.lch == PTR_W'(FRAMES - 1)) ? '0 : st_next.lch + PTR_W'(1);
        meta.ready_res = st_next.filled && (st_next.wp != lch_plus1);
        meta.filled    = st_next.filled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

// ===== design/ffwb_out.sv =====
// ----------------------------------------------------------------------------
// Result stage
// Pairs the store's read data with the request's status and holds the
// finished result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ffwb_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ffwb_pkg::meta_t      meta_in,
    input  logic [ffwb_pkg::VAL_W-1:0] rdata,
    output logic                 take_ok,
    ffwb_res_if.source           res
);

    import ffwb_pkg::*;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    meta_t            s1_meta_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_ready_reg;
    logic             out_filled_reg;
    logic             adv;

    // The read stage moves on whenever the output register is free or is
    // being emptied in this cycle.
    assign adv     = !out_valid_reg || res.ready;
    assign take_ok = !s1_valid_reg || adv;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_in;
        end
        if (adv && s1_valid_reg)
        begin
            out_value_reg  <= s1_meta_reg.rd_ok ? rdata : '0;
            out_ready_reg  <= s1_meta_reg.ready_res;
            out_filled_reg <= s1_meta_reg.filled;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.read_value = out_value_reg;
    assign res.ready_res  = out_ready_reg;
    assign res.filled     = out_filled_reg;

endmodule

// ===== design/feature_frame_window_buffer_core.sv =====
// ----------------------------------------------------------------------------
// Feature frame window buffer
// Circular store of coefficient frames with write, commit, read and consume.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (cmd, coef_index, frame_offset,
// coef_value); each accepted request yields exactly one result on the res
// channel (read_value, ready_res, filled), in request order.
// A request is taken in the cycle of its acceptance: the pointer, consumed
// head and filled flag are updated there and any store access it needs is
// issued to the RAM. The RAM's registered read data and the request's status
// meet in a read stage, and the finished result goes to an output register.
// A result passes through the read stage and then the output register before
// it is valid; throughput is one request per cycle while the receiver takes
// results, set by the one RAM port that each request uses for at most one access.
// While the receiver stalls, the output register holds its result and the
// read stage holds the next one; once both are full, req.ready drops and the
// RAM read data is kept because no new read is issued.
// Reset clears the write pointer, the consumed head, the filled flag and both
// stage valid flags. The coefficient store is not cleared: a slot that has
// never been written reads back as an unspecified value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module feature_frame_window_buffer_core (
    input  logic       clk,
    input  logic       rst_n,
    ffwb_req_if.sink   req,
    ffwb_res_if.source res
);

    import ffwb_pkg::*;

    req_t             req_pl;
    mem_req_t         mem_req;
    meta_t            meta;
    state_t           st;
    logic             accept;
    logic             take_ok;
    logic [VAL_W-1:0] rdata;

    assign req.ready = take_ok;
    assign accept    = req.valid && take_ok;

    assign req_pl.cmd          = req.cmd;
    assign req_pl.coef_index   = req.coef_index;
    assign req_pl.frame_offset = req.frame_offset;
    assign req_pl.coef_value   = req.coef_value;

    // Pointer state and address generation for the accepted request.
    ffwb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req_pl  (req_pl),
        .mem_req (mem_req),
        .meta    (meta),
        .st      (st)
    );

    // Coefficient store: one frame of COEFS entries per slot.
    ffwb_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    // Read stage and output register.
    ffwb_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .meta_in (meta),
        .rdata   (rdata),
        .take_ok (take_ok),
        .res     (res)
    );

    // A result can only report the window ready once the store has filled.
    `FFWB_ASSERT_NOW(a_ready_implies_filled, res.valid, !res.ready_res || res.filled, "ready without filled")

    // A commit at the last slot wraps the pointer and sets the filled flag.
    `FFWB_ASSERT_NEXT(a_commit_wraps, accept && req.cmd == CMD_COMMIT && st.wp == PTR_W'(FRAMES - 1), st.wp == '0 && st.filled, "commit at last slot did not wrap")

    // The filled flag never clears outside reset.
    `FFWB_ASSERT_NEXT(a_filled_sticky, st.filled, st.filled, "filled flag cleared")

    // The store is never asked to write and read in the same cycle.
    `FFWB_ASSERT(a_single_access, !(mem_req.we && mem_req.re), "store write and read together")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame window buffer testbench
// Drives write, commit, read and consume requests into the window buffer,
// predicts every result from a behavioural copy of the buffer state and
// checks each result in order, under several patterns of idling and stalls.
// ----------------------------------------------------------------------------

import ffwb_pkg::*;

// Behavioural copy of the window buffer and the queue of results it predicts.
class window_scoreboard;

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic                    ready_res;
        logic                    filled;
    } window_result_t;

    logic signed [VAL_W-1:0] coef_store [DEPTH];
    bit                      coef_written [DEPTH];
    int unsigned             written_addrs [$];
    logic [PTR_W-1:0]        wp;
    logic [PTR_W-1:0]        consumed_head;
    bit                      store_full;
    window_result_t          expected_results [$];
    int                      errors;

    function new();
        wp            = '0;
        consumed_head = '0;
        store_full    = 1'b0;
        errors        = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Applies one accepted request to the copy and queues its result.
    function void note_request(req_t r);
        window_result_t   res;
        int unsigned      addr;
        logic [PTR_W-1:0] frame;
        logic [PTR_W-1:0] head_next;
        res.read_value = '0;
        case (r.cmd)
            CMD_WRITE:
            begin
                if (r.coef_index < COEFS)
                begin
                    addr = wp * COEFS + r.coef_index;
                    coef_store[addr] = r.coef_value;
                    if (!coef_written[addr])
                    begin
                        coef_written[addr] = 1'b1;
                        written_addrs.push_back(addr);
                    end
                end
            end
            CMD_COMMIT:
            begin
                if (wp == FRAMES - 1)
                begin
                    wp         = '0;
                    store_full = 1'b1;
                end
                else
                begin
                    wp = wp + 1'b1;
                end
            end
            CMD_READ:
            begin
                if (r.coef_index < COEFS)
                begin
                    frame = (wp + r.frame_offset) % FRAMES;
                    res.read_value = coef_store[frame * COEFS + r.coef_index];
                end
            end
            default:
            begin
                consumed_head = (wp == 0) ? PTR_W'(FRAMES - 1) : wp - 1'b1;
            end
        endcase
        head_next     = (consumed_head + 1) % FRAMES;
        res.ready_res = store_full && (wp != head_next);
        res.filled    = store_full;
        expected_results.push_back(res);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(logic signed [VAL_W-1:0] read_value, logic ready_res,
                               logic filled);
        window_result_t exp;
        if (expected_results.size() == 0)
        begin
            $error("result received with no request outstanding");
            errors++;
            return;
        end
        exp = expected_results.pop_front();
        if (read_value !== exp.read_value)
        begin
            $error("read_value: expected %0d, got %0d", exp.read_value, read_value);
            errors++;
        end
        if (ready_res !== exp.ready_res)
        begin
            $error("ready_res: expected %0b, got %0b", exp.ready_res, ready_res);
            errors++;
        end
        if (filled !== exp.filled)
        begin
            $error("filled: expected %0b, got %0b", exp.filled, filled);
            errors++;
        end
    endfunction

endclass

module tb;

    // Random requests per idling phase; four phases give about 700 in all.
    localparam int PHASE_REQUESTS = 175;
    // Cycles with no handshake on either channel before the run is abandoned.
    // Idle and stall stretches are geometric, so a long quiet run is already
    // very unlikely; this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles waited after the last predicted result has arrived, so that a
    // spurious trailing result would still be caught.
    localparam int DRAIN_CYCLES   = 8;

    logic clk;
    logic rst_n;

    ffwb_req_if req_ch ();
    ffwb_res_if res_ch ();

    feature_frame_window_buffer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    window_scoreboard sb = new();

    // Percentages of cycles in which the sender holds back and the receiver
    // refuses a result. The main sequence changes them between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned res_stall_pct  = 0;
    int unsigned quiet_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver decides afresh at every edge whether it takes a result, so
    // stalls land on every phase of the two-stage output pipeline.
    initial
    begin
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
        end
    end

    // Results are sampled at the edge, before any of this edge's updates land,
    // so the values seen are exactly those that the handshake transferred.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            sb.check_result(res_ch.read_value, res_ch.ready_res, res_ch.filled);
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Presents one request, holding it until accepted. The idle cycles before
    // it lower valid; otherwise valid stays high straight into the next
    // request, so there is never more than one update of valid per edge.
    // The predictor is advanced here, before the next request is chosen, so
    // that reads can be aimed at coefficients that are known to be written.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= r.cmd;
        req_ch.coef_index   <= r.coef_index;
        req_ch.frame_offset <= r.frame_offset;
        req_ch.coef_value   <= r.coef_value;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_request(r);
    endtask

    task automatic send_fields(input cmd_t cmd, input int unsigned coef_index,
                               input int unsigned frame_offset, input int coef_value);
        req_t r;
        r.cmd          = cmd;
        r.coef_index   = coef_index;
        r.frame_offset = frame_offset;
        r.coef_value   = coef_value;
        send_request(r);
    endtask

    // Random request. Writes and commits dominate so that frames fill and the
    // pointer wraps round the ring; consumes are rarer so that the
    // window readiness flag spends time both set and clear. A read is always
    // aimed at a coefficient that has been written, because the contents of
    // an unwritten slot are unspecified; its frame offset is worked back from
    // the current write pointer, so every offset value occurs.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned addr;
        r.coef_index   = $urandom;
        r.frame_offset = $urandom;
        r.coef_value   = $urandom;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            r.cmd = CMD_WRITE;
        end
        else if (pick < 65)
        begin
            r.cmd = CMD_COMMIT;
        end
        else if (pick < 93)
        begin
            if (sb.written_addrs.size() == 0)
            begin
                r.cmd = CMD_WRITE;
            end
            else
            begin
                r.cmd = CMD_READ;
                addr = sb.written_addrs[$urandom_range(sb.written_addrs.size() - 1)];
                r.coef_index   = addr % COEFS;
                r.frame_offset = (addr / COEFS + FRAMES - sb.wp) % FRAMES;
            end
        end
        else
        begin
            r.cmd = CMD_CONSUME;
        end
        return r;
    endfunction

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_WRITE;
        req_ch.coef_index   = '0;
        req_ch.frame_offset = '0;
        req_ch.coef_value   = '0;
        res_ch.ready        = 1'b0;
        rst_n               = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling on either side. Coefficient extremes
        // go into both ends of frame zero and are read back before any commit.
        send_fields(CMD_WRITE, 0, 0, -128);
        send_fields(CMD_WRITE, COEFS - 1, 0, 127);
        send_fields(CMD_WRITE, 7, 0, 0);
        send_fields(CMD_WRITE, 8, 0, -1);
        send_fields(CMD_READ, 0, 0, 0);
        send_fields(CMD_READ, COEFS - 1, 0, 0);
        send_fields(CMD_READ, 7, 0, 0);
        send_fields(CMD_READ, 8, 0, 0);
        // Consume with the write pointer at zero: the head becomes the last
        // frame of the ring.
        send_fields(CMD_CONSUME, 0, 0, 0);
        send_fields(CMD_COMMIT, 0, 0, 0);
        send_fields(CMD_WRITE, 0, 31, 85);
        send_fields(CMD_WRITE, COEFS - 1, 31, -86);
        // Offset of 31 from pointer one wraps round to frame zero.
        send_fields(CMD_READ, 0, 31, 0);
        send_fields(CMD_READ, COEFS - 1, 31, 0);
        send_fields(CMD_READ, 0, 0, 0);
        send_fields(CMD_READ, COEFS - 1, 0, 0);
        send_fields(CMD_CONSUME, 0, 0, 0);
        send_fields(CMD_COMMIT, 0, 0, 0);

        // Random phases: free running, sender idling, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    res_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 74;
                    res_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    res_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct = 35;
                    res_stall_pct = 35;
                end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                send_request(random_request());
            end
        end
        req_ch.valid <= 1'b0;

        // Drain: the watchdog ends the run if results stop arriving.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ffwb_pkg.sv
design/ffwb_req_if.sv
design/ffwb_res_if.sv
design/ffwb_ram.sv
design/ffwb_ctrl.sv
design/ffwb_out.sv
design/feature_frame_window_buffer_core.sv
verif/tb.sv
